// ===== src/min_frequency_queue_macros.svh =====
// Assertion macros for the min_frequency_queue block.
// Used by the top level only; needs nothing else.
`ifndef MIN_FREQUENCY_QUEUE_MACROS_SVH
`define MIN_FREQUENCY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define MFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
`define MFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/mfq_pkg.sv =====
// Shared types and constants of the min_frequency_queue block.
// No dependencies.
package mfq_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int NODE_W       = 10;
	localparam int FREQ_W       = 32;
	localparam int COUNT_W      = 8;
	localparam int STATUS_W     = 2;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node_id;
		logic [FREQ_W-1:0] frequency;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NODE_W-1:0]   out_node_id;
		logic [FREQ_W-1:0]   out_frequency;
		logic [COUNT_W-1:0]  count;
	} out_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_id;
		logic [FREQ_W-1:0] frequency;
	} entry_t;

endpackage

// ===== src/mfq_store.sv =====
// Entry store of the queue: one write port, one read port, registered read.
// Depends on mfq_pkg.
module mfq_store import mfq_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/min_frequency_queue.sv =====
// Top level of the min_frequency_queue block: sequencer, count and result register.
// Depends on mfq_pkg, mfq_store and min_frequency_queue_macros.svh.
//
//  channel  | handshake      | payload
//  ---------+----------------+-------------------------------
//  request  | start / busy   | request (in_item_t)
//  result   | done (strobe)  | result  (out_item_t)
//
// Insert, or any item refused as full or empty: handled in idle, result strobed in the next cycle.
// Extract of n entries, lowest at place b: a scan of all n entries, one store
// read per cycle through the single compare unit, then one read and write per shift.
// Reset clears the count, the sequencer and the strobe; the store needs no clearing.
// The done strobe is high for one cycle only and cannot be stalled; result holds until the next.
`include "min_frequency_queue_macros.svh"
module min_frequency_queue import mfq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_SHIFT = 3'b100
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          done_q, done_d;
	out_item_t     result_q, result_d;
	entry_t        best_q, best_d;
	logic [AW-1:0] best_idx_q, best_idx_d;
	logic [AW-1:0] idx_q, idx_d;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t        wr_data, rd_data;

	logic          accept, at_last, take_new;
	entry_t        cand;
	logic [AW-1:0] cand_idx;
	logic [CW-1:0] count_dec;

	mfq_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign count_dec = count_q - CW'(1);
	assign at_last   = (CW'(idx_q) == count_dec);
	assign take_new  = (idx_q == '0) || (rd_data.frequency < best_q.frequency);
	assign cand      = take_new ? rd_data : best_q;
	assign cand_idx  = take_new ? idx_q : best_idx_q;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		done_d     = 1'b0;
		result_d   = result_q;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		idx_d      = idx_q;
		wr_en      = 1'b0;
		wr_addr    = AW'(count_q);
		wr_data    = '{node_id: request.node_id, frequency: request.frequency};
		rd_en      = 1'b0;
		rd_addr    = idx_q + AW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (request.kind == KIND_INSERT) begin
						done_d = 1'b1;
						if (count_q >= CW'(CAPACITY)) begin
							result_d = '{STATUS_FULL, '0, '0, COUNT_W'(count_q)};
						end else begin
							wr_en    = 1'b1;
							count_d  = count_q + CW'(1);
							result_d = '{STATUS_OK, '0, '0, COUNT_W'(count_q + CW'(1))};
						end
					end else if (count_q == '0) begin
						done_d   = 1'b1;
						result_d = '{STATUS_EMPTY, '0, '0, COUNT_W'(count_q)};
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						idx_d   = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en      = 1'b1;
				best_d     = cand;
				best_idx_d = cand_idx;
				if (!at_last) begin
					idx_d = idx_q + AW'(1);
				end else if (cand_idx == idx_q) begin
					count_d  = count_dec;
					done_d   = 1'b1;
					result_d = '{STATUS_OK, cand.node_id, cand.frequency, COUNT_W'(count_dec)};
					state_d  = ST_IDLE;
				end else begin
					rd_addr = cand_idx + AW'(1);
					idx_d   = cand_idx + AW'(1);
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				rd_en   = 1'b1;
				wr_en   = 1'b1;
				wr_addr = idx_q - AW'(1);
				wr_data = rd_data;
				if (!at_last) begin
					idx_d = idx_q + AW'(1);
				end else begin
					count_d  = count_dec;
					done_d   = 1'b1;
					result_d = '{STATUS_OK, best_q.node_id, best_q.frequency,
						COUNT_W'(count_dec)};
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q   <= result_d;
		best_q     <= best_d;
		best_idx_q <= best_idx_d;
		idx_q      <= idx_d;
	end

	assign done   = done_q;
	assign result = result_q;

	`MFQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count beyond capacity")
	`MFQ_ASSERT_NEXT(a_insert_done, clk, arst_n, accept && request.kind == KIND_INSERT, done && !busy, "insert not answered in one cycle")
	`MFQ_ASSERT_NEXT(a_empty_extract, clk, arst_n, accept && request.kind == KIND_EXTRACT && count_q == '0, done && result.status == STATUS_EMPTY, "extract on empty not reported")
	`MFQ_ASSERT_NOW(a_fail_zero, clk, arst_n, done && result.status != STATUS_OK, result.out_node_id == '0 && result.out_frequency == '0, "refused item carries an entry")
	`MFQ_ASSERT_NEXT(a_extract_dec, clk, arst_n, busy && done_d, count_q == $past(count_q) - CW'(1), "extract did not decrement count")

endmodule
